### rtl/xxh64_stream_hash_macros.svh
// ----------------------------------------------------------------------------
// xxh64_stream_hash_macros.svh
// Assertion macros shared by the hash block.
// ----------------------------------------------------------------------------
`ifndef XXH64_STREAM_HASH_MACROS_SVH
`define XXH64_STREAM_HASH_MACROS_SVH

// same-cycle implication
`define XXH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("xxh64 assertion failed");

// next-cycle implication
`define XXH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("xxh64 assertion failed");

`endif

### rtl/xxh_pkg.sv
// ----------------------------------------------------------------------------
// xxh_pkg
// Constants, types and helper functions of the XXH64 hash block.
// ----------------------------------------------------------------------------
package xxh_pkg;

    localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

    localparam logic REG_SEED = 1'b0;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] prod;
    } mul_rsp_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] mask_bytes(input logic [63:0] x, input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        mask_bytes = x & m;
    endfunction

endpackage

### rtl/xxh64_stream_hash.sv
// ----------------------------------------------------------------------------
// xxh64_stream_hash
// XXH64 of a streamed byte message, answering the low 32 bits of the hash.
// ----------------------------------------------------------------------------
// Words arrive as little-endian 8-byte chunks; tlast marks the final one,
// whose byte count (0..8) is honored. One shared multiplier, built from a
// 32x32 multiplier, forms each 64-bit product, and a small sequencer runs
// every product through it. A word that only fills the stripe buffer is
// taken in the idle state without a product. A word that completes a
// 32-byte stripe runs eight products. The last word runs the lane merge
// (twelve products, when a stripe completed), up to three 8-byte folds of
// three products each, a 4-byte fold, up to three 1-byte folds and the
// avalanche, two products per step except the merge and 8-byte folds.
// The result waits in an output register, so the next message can start
// while it is still unread.
module xxh64_stream_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // data_word[63:0], byte_count[67:64], zero pad
    input  logic        s_tlast,   // last_chunk
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hash_value[31:0]
);
    import xxh_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_LANE  = 10'b0000000010,
        ST_FIN   = 10'b0000000100,
        ST_MERGE = 10'b0000001000,
        ST_LEN   = 10'b0000010000,
        ST_FOLD8 = 10'b0000100000,
        ST_FOLD4 = 10'b0001000000,
        ST_FOLD1 = 10'b0010000000,
        ST_AVAL  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] seed_reg;
    logic [63:0] lane_reg [4];
    logic [63:0] lane_next [4];
    logic [63:0] pend_reg [3];
    logic [63:0] pend_next [3];
    logic [1:0]  wis_reg, wis_next;
    logic [63:0] len_reg, len_next;
    logic        sd_reg, sd_next;
    logic [63:0] data_reg, data_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] r_reg, r_next;
    logic [3:0]  rem_reg, rem_next;
    logic [1:0]  idx_reg, idx_next;
    logic [1:0]  sub_reg, sub_next;
    logic        fin_reg, fin_next;
    logic        wait_reg, wait_next;
    logic        ov_reg, ov_next;
    logic [31:0] od_reg, od_next;

    mul_req_t    mreq;
    mul_rsp_t    mrsp;
    logic [63:0] t;
    logic [63:0] sel_word, s_data_m;
    logic [3:0]  s_cnt, s_n;
    logic [2:0]  cnt8;
    logic        msg_start, out_free, wr_en;

    xxh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SEED);
    assign prdata = (paddr[2] == REG_SEED) ? seed_reg : 32'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign out_free = !ov_reg || m_tready;
    assign t        = mrsp.prod;

    assign s_cnt     = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
    assign s_n       = s_tlast ? s_cnt : 4'd8;
    assign s_data_m  = mask_bytes(s_tdata[63:0], s_n);
    assign msg_start = (len_reg == 64'd0) && !sd_reg && (wis_reg == 2'd0);
    assign cnt8      = {1'b0, wis_reg} + {2'b00, (rem_reg == 4'd8)};

    always_comb begin
        unique case (idx_reg)
            2'd0:    sel_word = (wis_reg > 2'd0) ? pend_reg[0] : data_reg;
            2'd1:    sel_word = (wis_reg > 2'd1) ? pend_reg[1] : data_reg;
            2'd2:    sel_word = (wis_reg > 2'd2) ? pend_reg[2] : data_reg;
            default: sel_word = data_reg;
        endcase
    end

    function automatic state_t tail_state(input logic [3:0] rem);
        if (rem >= 4'd4) begin
            tail_state = ST_FOLD4;
        end else if (rem != 4'd0) begin
            tail_state = ST_FOLD1;
        end else begin
            tail_state = ST_AVAL;
        end
    endfunction

    always_comb begin
        state_next = state_reg;
        lane_next  = lane_reg;
        pend_next  = pend_reg;
        wis_next   = wis_reg;
        len_next   = len_reg;
        sd_next    = sd_reg;
        data_next  = data_reg;
        h_next     = h_reg;
        r_next     = r_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        sub_next   = sub_reg;
        fin_next   = fin_reg;
        wait_next  = wait_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        mreq.start = 1'b0;
        mreq.a     = 64'd0;
        mreq.b     = PRIME1;

        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (msg_start) begin
                        lane_next[0] = {32'd0, seed_reg} + PRIME1 + PRIME2;
                        lane_next[1] = {32'd0, seed_reg} + PRIME2;
                        lane_next[2] = {32'd0, seed_reg};
                        lane_next[3] = {32'd0, seed_reg} - PRIME1;
                    end
                    data_next = s_data_m;
                    len_next  = len_reg + {60'd0, s_n};
                    idx_next  = 2'd0;
                    sub_next  = 2'd0;
                    fin_next  = s_tlast;
                    if (!s_tlast) begin
                        if (wis_reg == 2'd3) begin
                            state_next = ST_LANE;
                        end else begin
                            pend_next[wis_reg] = s_tdata[63:0];
                            wis_next = wis_reg + 2'd1;
                        end
                    end else if ((s_n == 4'd8) && (wis_reg == 2'd3)) begin
                        rem_next   = 4'd0;
                        state_next = ST_LANE;
                    end else begin
                        rem_next   = s_n;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_LANE: begin
                mreq.a = (sub_reg == 2'd0) ? sel_word : lane_reg[idx_reg];
                mreq.b = (sub_reg == 2'd0) ? PRIME2 : PRIME1;
                if (!wait_reg) begin
                    mreq.start = 1'b1;
                    wait_next  = 1'b1;
                end else if (mrsp.done) begin
                    wait_next = 1'b0;
                    if (sub_reg == 2'd0) begin
                        lane_next[idx_reg] = rotl(lane_reg[idx_reg] + t, 31);
                        sub_next = 2'd1;
                    end else begin
                        lane_next[idx_reg] = t;
                        sub_next = 2'd0;
                        idx_next = idx_reg + 2'd1;
                        if (idx_reg == 2'd3) begin
                            wis_next   = 2'd0;
                            sd_next    = 1'b1;
                            state_next = fin_reg ? ST_FIN : ST_IDLE;
                        end
                    end
                end
            end
            ST_FIN: begin
                idx_next = 2'd0;
                sub_next = 2'd0;
                if (sd_reg) begin
                    h_next = rotl(lane_reg[0], 1) + rotl(lane_reg[1], 7) +
                             rotl(lane_reg[2], 12) + rotl(lane_reg[3], 18);
                    state_next = ST_MERGE;
                end else begin
                    h_next     = lane_reg[2] + PRIME5;
                    state_next = ST_LEN;
                end
            end
            ST_MERGE, ST_FOLD8: begin
                unique case (sub_reg)
                    2'd0: begin
                        mreq.a = (state_reg == ST_MERGE) ? lane_reg[idx_reg] : sel_word;
                        mreq.b = PRIME2;
                    end
                    2'd1: begin
                        mreq.a = r_reg;
                        mreq.b = PRIME1;
                    end
                    default: begin
                        mreq.a = (state_reg == ST_MERGE) ? h_reg : rotl(h_reg, 27);
                        mreq.b = PRIME1;
                    end
                endcase
                if (!wait_reg) begin
                    mreq.start = 1'b1;
                    wait_next  = 1'b1;
                end else if (mrsp.done) begin
                    wait_next = 1'b0;
                    unique case (sub_reg)
                        2'd0: begin
                            r_next   = rotl(t, 31);
                            sub_next = 2'd1;
                        end
                        2'd1: begin
                            h_next   = h_reg ^ t;
                            sub_next = 2'd2;
                        end
                        default: begin
                            h_next   = t + PRIME4;
                            sub_next = 2'd0;
                            idx_next = idx_reg + 2'd1;
                            if (state_reg == ST_MERGE) begin
                                if (idx_reg == 2'd3) begin
                                    state_next = ST_LEN;
                                end
                            end else if ({1'b0, idx_reg} == cnt8 - 3'd1) begin
                                if (rem_reg == 4'd8) begin
                                    rem_next = 4'd0;
                                end
                                state_next = tail_state((rem_reg == 4'd8) ? 4'd0 : rem_reg);
                            end
                        end
                    endcase
                end
            end
            ST_LEN: begin
                h_next   = h_reg + len_reg;
                idx_next = 2'd0;
                sub_next = 2'd0;
                state_next = (cnt8 != 3'd0) ? ST_FOLD8 : tail_state(rem_reg);
            end
            ST_FOLD4, ST_FOLD1: begin
                if (state_reg == ST_FOLD4) begin
                    mreq.a = (sub_reg == 2'd0) ? {32'd0, data_reg[31:0]} : rotl(h_reg, 23);
                    mreq.b = (sub_reg == 2'd0) ? PRIME1 : PRIME2;
                end else begin
                    mreq.a = (sub_reg == 2'd0) ? {56'd0, data_reg[7:0]} : rotl(h_reg, 11);
                    mreq.b = (sub_reg == 2'd0) ? PRIME5 : PRIME1;
                end
                if (!wait_reg) begin
                    mreq.start = 1'b1;
                    wait_next  = 1'b1;
                end else if (mrsp.done) begin
                    wait_next = 1'b0;
                    if (sub_reg == 2'd0) begin
                        h_next   = h_reg ^ t;
                        sub_next = 2'd1;
                    end else begin
                        sub_next = 2'd0;
                        if (state_reg == ST_FOLD4) begin
                            h_next     = t + PRIME3;
                            data_next  = data_reg >> 32;
                            rem_next   = rem_reg - 4'd4;
                            state_next = tail_state(rem_reg - 4'd4);
                        end else begin
                            h_next     = t;
                            data_next  = data_reg >> 8;
                            rem_next   = rem_reg - 4'd1;
                            state_next = tail_state(rem_reg - 4'd1);
                        end
                    end
                end
            end
            ST_AVAL: begin
                mreq.a = (sub_reg == 2'd0) ? (h_reg ^ (h_reg >> 33)) : h_reg;
                mreq.b = (sub_reg == 2'd0) ? PRIME2 : PRIME3;
                if (!wait_reg) begin
                    mreq.start = 1'b1;
                    wait_next  = 1'b1;
                end else if (mrsp.done) begin
                    wait_next = 1'b0;
                    if (sub_reg == 2'd0) begin
                        h_next   = t ^ (t >> 29);
                        sub_next = 2'd1;
                    end else begin
                        h_next     = t ^ (t >> 32);
                        sub_next   = 2'd0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    od_next    = h_reg[31:0];
                    wis_next   = 2'd0;
                    len_next   = 64'd0;
                    sd_next    = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seed_reg  <= 32'd0;
            wis_reg   <= 2'd0;
            len_reg   <= 64'd0;
            sd_reg    <= 1'b0;
            wait_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            idx_reg   <= 2'd0;
            sub_reg   <= 2'd0;
            fin_reg   <= 1'b0;
            rem_reg   <= 4'd0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                seed_reg <= pwdata;
            end
            wis_reg   <= wis_next;
            len_reg   <= len_next;
            sd_reg    <= sd_next;
            wait_reg  <= wait_next;
            ov_reg    <= ov_next;
            idx_reg   <= idx_next;
            sub_reg   <= sub_next;
            fin_reg   <= fin_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        lane_reg <= lane_next;
        pend_reg <= pend_next;
        data_reg <= data_next;
        h_reg    <= h_next;
        r_reg    <= r_next;
        od_reg   <= od_next;
    end

`include "xxh64_stream_hash_macros.svh"

    `XXH_ASSERT_NOW(a_start_idle, mreq.start, !mrsp.busy)
    `XXH_ASSERT_NOW(a_done_waited, mrsp.done, wait_reg)
    `XXH_ASSERT_NEXT(a_out_loaded, (state_reg == ST_OUT) && out_free, m_tvalid && s_tready)

endmodule

### rtl/xxh_mul.sv
// ----------------------------------------------------------------------------
// xxh_mul
// Shared 64x64 multiplier, low 64 bits of the product, built from one
// 32x32 multiplier in three steps.
// ----------------------------------------------------------------------------
module xxh_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  xxh_pkg::mul_req_t req,
    output xxh_pkg::mul_rsp_t rsp
);
    import xxh_pkg::*;

    logic [63:0] a_reg, b_reg, acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg, done_reg;
    logic [31:0] ma, mb;
    logic [63:0] pp;

    always_comb begin
        unique case (step_reg)
            2'd0: begin
                ma = a_reg[31:0];
                mb = b_reg[31:0];
            end
            2'd1: begin
                ma = a_reg[31:0];
                mb = b_reg[63:32];
            end
            default: begin
                ma = a_reg[63:32];
                mb = b_reg[31:0];
            end
        endcase
        pp = {32'd0, ma} * {32'd0, mb};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end else if (busy_reg) begin
                if (step_reg == 2'd2) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    step_reg <= 2'd0;
                end else begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg <= req.a;
            b_reg <= req.b;
        end else if (busy_reg) begin
            if (step_reg == 2'd0) begin
                acc_reg <= pp;
            end else begin
                acc_reg[63:32] <= acc_reg[63:32] + pp[31:0];
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

### verif/xxh64_stream_hash_checker.sv
// ----------------------------------------------------------------------------
// xxh64_stream_hash_checker
// Predicts and checks the low 32 bits of each XXH64 message hash.
// ----------------------------------------------------------------------------
// Watches the seed register writes and the input word stream, keeps its own
// copy of the lanes, stripe buffer and length, and computes the hash on every
// last word. Each hash leaving the block is compared with the oldest one
// computed; mismatches and unexpected hashes are counted.
// ----------------------------------------------------------------------------
module xxh64_stream_hash_checker
    import xxh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // data_word[63:0], byte_count[67:64], zero pad
    input  logic        s_tlast,   // last_chunk
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // hash_value[31:0]
    output int          mismatches,
    output int          hashes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] SEED_ADDR = 3'd0;

    logic [63:0] seed_q;
    logic [63:0] lane [4];
    logic [63:0] stripe_buf [3];
    int unsigned buf_words;
    logic [63:0] msg_bytes;
    bit          stripe_seen;
    logic [31:0] hash_queue [$];

    function automatic logic [63:0] rot64(logic [63:0] x, int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] lane_mix(logic [63:0] acc, logic [63:0] w);
        return rot64(acc + w * PRIME2, 31) * PRIME1;
    endfunction

    function automatic logic [63:0] fold_word(logic [63:0] h, logic [63:0] w);
        return rot64(h ^ lane_mix(64'd0, w), 27) * PRIME1 + PRIME4;
    endfunction

    task automatic start_lanes();
        lane[0] = seed_q + PRIME1 + PRIME2;
        lane[1] = seed_q + PRIME2;
        lane[2] = seed_q;
        lane[3] = seed_q - PRIME1;
    endtask

    task automatic absorb(logic [63:0] w);
        if (buf_words < 3) begin
            stripe_buf[buf_words] = w;
            buf_words++;
        end else begin
            for (int i = 0; i < 3; i++) lane[i] = lane_mix(lane[i], stripe_buf[i]);
            lane[3] = lane_mix(lane[3], w);
            buf_words = 0;
            stripe_seen = 1;
        end
    endtask

    function automatic logic [31:0] finish_hash(logic [63:0] data, int unsigned rem);
        logic [63:0] h;
        if (stripe_seen) begin
            h = rot64(lane[0], 1) + rot64(lane[1], 7) + rot64(lane[2], 12)
                + rot64(lane[3], 18);
            for (int i = 0; i < 4; i++) h = (h ^ lane_mix(64'd0, lane[i])) * PRIME1 + PRIME4;
        end else begin
            h = lane[2] + PRIME5;
        end
        h += msg_bytes;
        for (int i = 0; i < buf_words; i++) h = fold_word(h, stripe_buf[i]);
        if (rem == 8) begin
            h = fold_word(h, data);
            rem = 0;
        end
        if (rem >= 4) begin
            h ^= {32'd0, data[31:0]} * PRIME1;
            h = rot64(h, 23) * PRIME2 + PRIME3;
            data >>= 32;
            rem -= 4;
        end
        while (rem > 0) begin
            h ^= {56'd0, data[7:0]} * PRIME5;
            h = rot64(h, 11) * PRIME1;
            data >>= 8;
            rem--;
        end
        h ^= h >> 33;
        h *= PRIME2;
        h ^= h >> 29;
        h *= PRIME3;
        h ^= h >> 32;
        return h[31:0];
    endfunction

    task automatic take_word(logic [63:0] data, logic [3:0] cnt, logic last);
        int unsigned n;
        int unsigned rem;
        if (msg_bytes == 0 && !stripe_seen && buf_words == 0) start_lanes();
        if (!last) begin
            absorb(data);
            msg_bytes += 8;
            return;
        end
        n = (cnt > 8) ? 8 : cnt;
        for (int b = n; b < 8; b++) data[b*8 +: 8] = 8'h00;
        msg_bytes += n;
        rem = n;
        if (n == 8 && buf_words == 3) begin
            absorb(data);
            rem = 0;
        end
        hash_queue.push_back(finish_hash(data, rem));
        buf_words = 0;
        msg_bytes = 0;
        stripe_seen = 0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_q = '0;
            buf_words = 0;
            msg_bytes = '0;
            stripe_seen = 0;
            mismatches = 0;
            start_lanes();
        end else begin
            if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
                seed_q = {32'd0, pwdata};
            if (m_tvalid && m_tready) begin
                if (hash_queue.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected hash %h", m_tdata);
                    mismatches++;
                end else begin
                    if (m_tdata !== hash_queue[0]) begin
                        if (mismatches < 10)
                            $display("hash mismatch: expected %h actual %h",
                                     hash_queue[0], m_tdata);
                        mismatches++;
                    end
                    void'(hash_queue.pop_front());
                end
            end
            if (s_tvalid && s_tready) take_word(s_tdata[63:0], s_tdata[67:64], s_tlast);
        end
        hashes_owed = hash_queue.size();
    end
endmodule

### verif/xxh64_stream_hash_test.sv
// ----------------------------------------------------------------------------
// xxh64_stream_hash_test
// Stream testbench of the XXH64 hash block.
// ----------------------------------------------------------------------------
// Sends directed and random messages of varied length, tail size and seed,
// with random idling on both channels, one long output stall and a drain
// pause after each phase. The checker beside the block predicts every hash and counts errors.
// ----------------------------------------------------------------------------
module xxh64_stream_hash_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] SEED_ADDR  = 3'd0;
    localparam int         LIMIT      = 3000000;
    localparam int         DRAIN_WAIT = 300;
    localparam int         HOLD_LEN   = 3000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    int          mismatches;
    int          hashes_owed;
    int          send_idle_pct = 16;
    int          recv_idle_pct = 79;
    bit          hold_req = 0;
    bit          hold_done = 0;
    int          hold_left = 0;
    int          cycles = 0;
    int          words_sent = 0;

    xxh64_stream_hash dut (.*);

    xxh64_stream_hash_checker checker_i (.*);

    initial forever #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("xxh64_stream_hash_test: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1;
            hold_left <= HOLD_LEN;
            m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_seed(logic [31:0] value);
        psel <= 1;
        pwrite <= 1;
        paddr <= SEED_ADDR;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (hashes_owed != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic last);
        s_tvalid <= 1;
        s_tdata <= {4'd0, cnt, data};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    function automatic logic [63:0] rand_data();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_message(int body, logic [3:0] tail_cnt);
        for (int i = 0; i < body; i++) send_word(rand_data(), 4'($urandom_range(15)), 0);
        send_word(rand_data(), tail_cnt, 1);
    endtask

    task automatic random_phase(int words);
        int body;
        int stop;
        stop = words_sent + words;
        while (words_sent < stop) begin
            body = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(8);
            send_message(body, 4'($urandom_range(15)));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_word('1, 4'd0, 1);
        send_word('1, 4'd8, 1);
        send_word('1, 4'd15, 1);
        send_word(64'h0102030405060708, 4'd4, 1);
        send_word(64'h0102030405060708, 4'd3, 1);
        send_word('0, 4'd8, 0);
        send_word('1, 4'd7, 1);
        for (int i = 0; i < 3; i++) send_word('1, 4'd15, 0);
        send_word('1, 4'd8, 1);
        for (int i = 0; i < 4; i++) send_word({$urandom, $urandom}, 4'd0, 0);
        send_word('1, 4'd5, 1);
        for (int i = 0; i < 5; i++) send_word('0, 4'd8, 0);
        send_word(64'h8000000000000001, 4'd12, 1);
        drain();

        write_seed(32'hFFFF_FFFF);
        random_phase(350);
        drain();

        send_idle_pct = 79;
        recv_idle_pct = 16;
        write_seed($urandom);
        random_phase(200);
        drain();
        random_phase(150);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_seed(32'h0000_0001);
        hold_req <= 1;
        random_phase(200);
        drain();
        write_seed(32'h0000_0000);
        random_phase(200);
        drain();

        if (mismatches == 0 && hashes_owed == 0) begin
            $display("xxh64_stream_hash_test: PASS");
        end else begin
            $display("xxh64_stream_hash_test: FAIL");
        end
        $finish;
    end
endmodule
